/* sv/ast_pkg.sv */
// ----------------------------------------------------------------------------
// ast_pkg - shared types for the array set table
// Operation codes and the control word that the top level sends to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package ast_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef struct packed {
		logic capture;    // compare the key against the stored word
		logic load_token; // start a shift-down wave at the matching cell
		logic step;       // one shift-down step along the chain
	} cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/array_set_table.sv */
// Query and insert give their result word after the compare and decide steps;
// a delete that hits entry p of n held items also walks a token from p to the tail.
// A new request is taken only once the last result word is out and busy is low;
// a delete is paced by the token walking one cell per cycle down the chain.
// Reset clears the count, so the set is empty at once; no clearing pass.
// done strobes for one cycle and the receiver cannot stall.
// ----------------------------------------------------------------------------
// array_set_table - set of distinct items kept in order of arrival
// A chain of cells holds the packed store; insert appends, delete shifts the
// tail down one cell at a time, query only looks.
// ----------------------------------------------------------------------------
`default_nettype none

module array_set_table #(
	parameter int CAPACITY   = 64,
	parameter int ITEM_WIDTH = 8
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	input  wire logic [1:0]                    operation,
	input  wire logic [ITEM_WIDTH-1:0]         item_value,
	output logic                               busy,
	output logic                               done,
	output logic                               was_present,
	output logic                               full_refused,
	output logic [$clog2(CAPACITY+1)-1:0]      element_count
);

	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_DECIDE = 3'b010,
		ST_SHIFT  = 3'b100
	} state_t;

	state_t                state_q;
	logic [1:0]            op_q;
	logic [ITEM_WIDTH-1:0] key_q;
	logic [CW-1:0]         count_q;
	logic                  done_q;
	logic                  was_present_q;
	logic                  full_refused_q;
	logic [CW-1:0]         element_count_q;

	ast_pkg::cell_ctrl_t   ctrl;
	logic [ITEM_WIDTH-1:0] key_bus;
	logic                  accept;
	logic                  insert_go;
	logic                  present;
	logic                  full;
	logic                  finish;

	logic [ITEM_WIDTH-1:0] value_vec [CAPACITY];
	logic [ITEM_WIDTH-1:0] next_vec  [CAPACITY];
	logic [CAPACITY-1:0]   valid_vec;
	logic [CAPACITY-1:0]   last_vec;
	logic [CAPACITY-1:0]   wr_vec;
	logic [CAPACITY-1:0]   hit_vec;
	logic [CAPACITY-1:0]   token_vec;
	logic [CAPACITY-1:0]   token_in_vec;

	assign accept  = start && (state_q == ST_IDLE);
	// compare against the incoming word at accept, write the latched one later
	assign key_bus = (state_q == ST_IDLE) ? item_value : key_q;
	assign present = |hit_vec;
	assign full    = (count_q == CW'(CAPACITY));
	// the token drops out of sight once it sits in the last valid cell
	assign finish  = (state_q == ST_SHIFT) && !(|token_vec);
	assign insert_go = (state_q == ST_DECIDE) && (op_q == ast_pkg::OP_INSERT)
		&& !present && !full;

	assign ctrl.capture    = accept;
	assign ctrl.load_token = (state_q == ST_DECIDE) && (op_q == ast_pkg::OP_DELETE) && present;
	assign ctrl.step       = (state_q == ST_SHIFT);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign valid_vec[i] = (CW'(i) < count_q);
		assign last_vec[i]  = (count_q == CW'(i + 1));
		assign wr_vec[i]    = insert_go && (count_q == CW'(i));

		if (i == CAPACITY - 1) begin : g_end
			assign next_vec[i] = '0;
		end else begin : g_mid
			assign next_vec[i] = value_vec[i + 1];
		end

		if (i == 0) begin : g_head
			assign token_in_vec[i] = 1'b0;
		end else begin : g_link
			assign token_in_vec[i] = token_vec[i - 1] && !last_vec[i - 1];
		end

		ast_cell #(
			.ITEM_WIDTH(ITEM_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.key       (key_bus),
			.next_value(next_vec[i]),
			.valid     (valid_vec[i]),
			.last      (last_vec[i]),
			.wr_en     (wr_vec[i]),
			.token_in  (token_in_vec[i]),
			.value     (value_vec[i]),
			.hit       (hit_vec[i]),
			.token_out (token_vec[i])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			key_q <= item_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			count_q         <= '0;
			done_q          <= 1'b0;
			was_present_q   <= 1'b0;
			full_refused_q  <= 1'b0;
			element_count_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					was_present_q   <= present;
					full_refused_q  <= 1'b0;
					element_count_q <= count_q;
					unique case (op_q)
						ast_pkg::OP_INSERT: begin
							done_q         <= 1'b1;
							state_q        <= ST_IDLE;
							full_refused_q <= !present && full;
							if (insert_go) begin
								count_q         <= count_q + CW'(1);
								element_count_q <= count_q + CW'(1);
							end
						end
						ast_pkg::OP_DELETE: begin
							if (present) begin
								state_q <= ST_SHIFT;
							end else begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end
						end
						ast_pkg::OP_QUERY: begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_SHIFT: begin
					if (finish) begin
						done_q          <= 1'b1;
						state_q         <= ST_IDLE;
						count_q         <= count_q - CW'(1);
						element_count_q <= count_q - CW'(1);
						was_present_q   <= 1'b1;
						full_refused_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign was_present   = was_present_q;
	assign full_refused  = full_refused_q;
	assign element_count = element_count_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while still busy");

	a_refused_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && full_refused |-> element_count == CW'(CAPACITY))
		else $error("insert refused with room left");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECIDE |-> $onehot0(hit_vec))
		else $error("duplicate item in store");

	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(token_vec))
		else $error("more than one delete token");

	a_shift_count: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> count_q == $past(count_q) - CW'(1))
		else $error("count not lowered after delete");

endmodule

`default_nettype wire

/* sv/ast_cell.sv */
// ----------------------------------------------------------------------------
// ast_cell - one storage cell of the set chain
// Holds one word, compares it with the key and moves its right neighbor's
// word in while the delete token passes through.
// ----------------------------------------------------------------------------
`default_nettype none

module ast_cell #(
	parameter int ITEM_WIDTH = 8
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire ast_pkg::cell_ctrl_t   ctrl,
	input  wire logic [ITEM_WIDTH-1:0] key,
	input  wire logic [ITEM_WIDTH-1:0] next_value,
	input  wire logic                  valid,
	input  wire logic                  last,
	input  wire logic                  wr_en,
	input  wire logic                  token_in,
	output logic [ITEM_WIDTH-1:0]      value,
	output logic                       hit,
	output logic                       token_out
);

	logic [ITEM_WIDTH-1:0] value_q;
	logic                  hit_q;
	logic                  token_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			value_q <= key;
		end else if (ctrl.step && token_q && !last) begin
			value_q <= next_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			token_q <= 1'b0;
		end else begin
			if (ctrl.capture) begin
				hit_q <= valid && (value_q == key);
			end
			if (ctrl.load_token) begin
				token_q <= hit_q;
			end else if (ctrl.step) begin
				token_q <= token_in;
			end
		end
	end

	assign value     = value_q;
	assign hit       = hit_q;
	// the last valid cell swallows the token
	assign token_out = token_q && !last;

endmodule

`default_nettype wire
